// ===== rtl/congruential_generator_histogram_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the congruential generator block
// Shared property forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CONGRUENTIAL_GENERATOR_HISTOGRAM_ASSERT_SVH
`define CONGRUENTIAL_GENERATOR_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define CGH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cgh property failed");

// next-cycle implication
`define CGH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cgh property failed");

`endif

// ===== rtl/cgh_pkg.sv =====
// ----------------------------------------------------------------------------
// cgh_pkg
// Types and fixed constants of the congruential generator with histogram.
// ----------------------------------------------------------------------------
package cgh_pkg;

	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int KIND_BITS    = 2;
	localparam int SEL_BITS     = 4;
	localparam int MODE_BITS    = 2;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MULT_A  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_INCR_C  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_QUAD_D  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 3'd4;

	// reset values
	localparam logic [MODE_BITS-1:0] MODE_RST    = 2'd0;
	localparam logic [CFG_BITS-1:0]  MULT_A_RST  = 16'd29;
	localparam logic [CFG_BITS-1:0]  INCR_C_RST  = 16'd31;
	localparam logic [CFG_BITS-1:0]  QUAD_D_RST  = 16'd33;
	localparam logic [CFG_BITS-1:0]  MODULUS_RST = 16'd131;
	localparam logic [CFG_BITS-1:0]  MODULUS_MIN = 16'd2;

	// recurrence modes
	localparam logic [MODE_BITS-1:0] MODE_LIN  = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_QUAD = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_FIB  = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_INV  = 2'd3;

	// item kinds
	localparam logic [KIND_BITS-1:0] KIND_GEN   = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

	typedef enum logic {
		ALU_MUL,
		ALU_ADD
	} alu_op_t;

	typedef struct packed {
		logic    go;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_X,
		ST_RED_C,
		ST_RED_A,
		ST_RED_P,
		ST_MUL_DX,
		ST_ADD_A,
		ST_MUL_RX,
		ST_INV_INIT,
		ST_INV,
		ST_MUL_AX,
		ST_ADD_C,
		ST_ADD_P,
		ST_BIN,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/cgh_modalu.sv =====
// ----------------------------------------------------------------------------
// cgh_modalu
// Shared modular unit: bit-serial (opnd * addend) mod m, MSB first, one
// operand bit per cycle, or a registered (opnd + addend) mod m.
// addend and the low bits of opnd for an add must be below m.
// ----------------------------------------------------------------------------
module cgh_modalu import cgh_pkg::*; #(
	parameter int OPW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  alu_req_t            req,
	input  logic [OPW-1:0]      opnd,
	input  logic [CFG_BITS-1:0] addend,
	input  logic [CFG_BITS-1:0] modulus,
	output logic                done,
	output logic [CFG_BITS-1:0] res
);

	localparam int CW = $clog2(OPW);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [OPW-1:0]      sh_q;
	logic [CFG_BITS-1:0] b_q;
	logic [CFG_BITS-1:0] r_q;
	logic                start;

	logic [CFG_BITS:0] m_ext;
	logic [CFG_BITS:0] dbl, dbl_r, sum, sum_r, add_s, add_r;

	// a request held across the done cycle is not taken twice
	assign start = req.go && !busy_q && !done_q;

	always_comb begin
		m_ext = {1'b0, modulus};
		dbl   = {r_q, 1'b0};
		dbl_r = (dbl >= m_ext) ? dbl - m_ext : dbl;
		sum   = dbl_r + (sh_q[OPW-1] ? {1'b0, b_q} : '0);
		sum_r = (sum >= m_ext) ? sum - m_ext : sum;
		add_s = {1'b0, opnd[CFG_BITS-1:0]} + {1'b0, addend};
		add_r = (add_s >= m_ext) ? add_s - m_ext : add_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (busy_q) begin
				done_q <= (cnt_q == '0);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (start) begin
				unique case (req.op)
					ALU_MUL: begin
						busy_q <= 1'b1;
						done_q <= 1'b0;
						cnt_q  <= CW'(OPW - 1);
					end
					ALU_ADD: begin
						done_q <= 1'b1;
					end
				endcase
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			r_q  <= sum_r[CFG_BITS-1:0];
			sh_q <= {sh_q[OPW-2:0], 1'b0};
		end else if (start) begin
			unique case (req.op)
				ALU_MUL: begin
					r_q  <= '0;
					sh_q <= opnd;
					b_q  <= addend;
				end
				ALU_ADD: begin
					r_q <= add_r[CFG_BITS-1:0];
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

// ===== rtl/congruential_generator_histogram.sv =====
// ----------------------------------------------------------------------------
// congruential_generator_histogram
// Multi-mode congruential generator with a saturating decile histogram.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : kind, bin_select with item_valid/item_ready.
//   result channel : value, bin, bin_count, no_inverse with result_valid/
//                    result_ready; one result per item, in order.
//   cfg channel    : cfg_index/cfg_data with cfg_valid/cfg_ready, always
//                    ready; write only while the block is idle.
// One item at a time: item_ready is high only in idle. A generate first
// reduces its operands mod m on the shared unit, then forms a*x+c in linear
// mode, (d*x+a)*x+c in quadratic, x+prev in fibonacci and a*inv(x)+c in
// inverse mode after an inverse search; a serial division finds the bin.
// Read and clear items go straight to the result step.
// The result sits in an output register; a new item is taken while it
// waits, and a stalled receiver only holds the sequencer at its last step.
// Reset: mode 0, a=29, c=31, d=33, m=131, both values 1, counts zero.
// ----------------------------------------------------------------------------
module congruential_generator_histogram import cgh_pkg::*; #(
	parameter int VALUE_BITS = 16,
	parameter int NUM_BINS   = 10,
	parameter int COUNT_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [KIND_BITS-1:0]    kind,
	input  logic [SEL_BITS-1:0]     bin_select,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [VALUE_BITS-1:0]   value,
	output logic [SEL_BITS-1:0]     bin,
	output logic [COUNT_BITS-1:0]   bin_count,
	output logic                    no_inverse,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	localparam int OPW = (VALUE_BITS > CFG_BITS) ? VALUE_BITS : CFG_BITS;
	localparam int QB  = $clog2(NUM_BINS);
	localparam int RW  = CFG_BITS + QB;
	localparam int BCW = $clog2(QB + 1);

	// configuration
	logic [MODE_BITS-1:0] mode_q;
	logic [CFG_BITS-1:0]  mult_a_q, incr_c_q, quad_d_q, modulus_q;
	logic [CFG_BITS-1:0]  m_eff;

	// sequencer and generator state
	state_t                state_q, state_d;
	logic [VALUE_BITS-1:0] cur_q, prev_q;
	logic [COUNT_BITS-1:0] hist_q [NUM_BINS];
	logic                  result_valid_q;

	// working registers
	logic [KIND_BITS-1:0]  kind_q;
	logic [SEL_BITS-1:0]   sel_q;
	logic [CFG_BITS-1:0]   x_q, t_q, p_q, r_q, i_q, prod_q;
	logic                  flag_q;
	logic [RW-1:0]         rem_q, dv_q;
	logic [QB-1:0]         bin_q;
	logic [BCW-1:0]        bcnt_q;

	// output registers
	logic [VALUE_BITS-1:0] value_q;
	logic [SEL_BITS-1:0]   bin_out_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  no_inv_q;

	// shared unit
	alu_req_t              alu_req;
	logic [OPW-1:0]        alu_opnd;
	logic [CFG_BITS-1:0]   alu_b;
	logic                  alu_done;
	logic [CFG_BITS-1:0]   alu_res;

	logic                  accept, fire, bin_ge, sel_ok;
	logic [QB-1:0]         gen_idx, rd_idx;
	logic [COUNT_BITS-1:0] rd_cnt, cnt_inc;

	assign m_eff      = (modulus_q < MODULUS_MIN) ? MODULUS_MIN : modulus_q;
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign fire       = (state_q == ST_FIN) && (!result_valid_q || result_ready);
	assign cfg_ready  = 1'b1;

	assign bin_ge  = (rem_q >= dv_q);
	assign gen_idx = ({1'b0, bin_q} >= (QB + 1)'(NUM_BINS)) ? QB'(NUM_BINS - 1) : bin_q;
	assign rd_idx  = (kind_q == KIND_GEN) ? gen_idx : sel_q[QB-1:0];
	assign rd_cnt  = hist_q[rd_idx];
	assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
	assign sel_ok  = ({1'b0, sel_q} < (SEL_BITS + 1)'(NUM_BINS));

	cgh_modalu #(
		.OPW(OPW)
	) u_cgh_modalu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opnd   (alu_opnd),
		.addend (alu_b),
		.modulus(m_eff),
		.done   (alu_done),
		.res    (alu_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid)
					state_d = (kind == KIND_GEN) ? ST_RED_X : ST_FIN;
			end
			ST_RED_X: begin
				if (alu_done)
					state_d = (mode_q == MODE_FIB) ? ST_RED_P : ST_RED_C;
			end
			ST_RED_C: begin
				if (alu_done) begin
					unique case (mode_q)
						MODE_LIN:  state_d = ST_MUL_AX;
						MODE_QUAD: state_d = ST_RED_A;
						MODE_FIB:  state_d = ST_MUL_AX;
						MODE_INV:  state_d = ST_INV_INIT;
					endcase
				end
			end
			ST_RED_A:    if (alu_done) state_d = ST_MUL_DX;
			ST_MUL_DX:   if (alu_done) state_d = ST_ADD_A;
			ST_ADD_A:    if (alu_done) state_d = ST_MUL_RX;
			ST_MUL_RX:   if (alu_done) state_d = ST_ADD_C;
			ST_RED_P:    if (alu_done) state_d = ST_ADD_P;
			ST_INV_INIT: state_d = ST_INV;
			ST_INV: begin
				if (prod_q == CFG_BITS'(1) || i_q == '0)
					state_d = ST_MUL_AX;
			end
			ST_MUL_AX:   if (alu_done) state_d = ST_ADD_C;
			ST_ADD_C:    if (alu_done) state_d = ST_BIN;
			ST_ADD_P:    if (alu_done) state_d = ST_BIN;
			ST_BIN:      if (bcnt_q == BCW'(QB - 1)) state_d = ST_FIN;
			ST_FIN:      if (fire) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// shared unit requests
	always_comb begin
		alu_req  = '{go: 1'b0, op: ALU_MUL};
		alu_opnd = '0;
		alu_b    = CFG_BITS'(1);
		unique case (state_q)
			ST_RED_X: begin
				alu_req  = '{go: 1'b1, op: ALU_MUL};
				alu_opnd = OPW'(cur_q);
			end
			ST_RED_C: begin
				alu_req  = '{go: 1'b1, op: ALU_MUL};
				alu_opnd = OPW'(incr_c_q);
			end
			ST_RED_A: begin
				alu_req  = '{go: 1'b1, op: ALU_MUL};
				alu_opnd = OPW'(mult_a_q);
			end
			ST_RED_P: begin
				alu_req  = '{go: 1'b1, op: ALU_MUL};
				alu_opnd = OPW'(prev_q);
			end
			ST_MUL_DX: begin
				alu_req  = '{go: 1'b1, op: ALU_MUL};
				alu_opnd = OPW'(quad_d_q);
				alu_b    = x_q;
			end
			ST_ADD_A: begin
				alu_req  = '{go: 1'b1, op: ALU_ADD};
				alu_opnd = OPW'(r_q);
				alu_b    = p_q;
			end
			ST_MUL_RX: begin
				alu_req  = '{go: 1'b1, op: ALU_MUL};
				alu_opnd = OPW'(r_q);
				alu_b    = x_q;
			end
			ST_MUL_AX: begin
				alu_req  = '{go: 1'b1, op: ALU_MUL};
				alu_opnd = OPW'(mult_a_q);
				alu_b    = (mode_q == MODE_INV) ? p_q : x_q;
			end
			ST_ADD_C: begin
				alu_req  = '{go: 1'b1, op: ALU_ADD};
				alu_opnd = OPW'(r_q);
				alu_b    = t_q;
			end
			ST_ADD_P: begin
				alu_req  = '{go: 1'b1, op: ALU_ADD};
				alu_opnd = OPW'(x_q);
				alu_b    = p_q;
			end
			default: ;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			mode_q         <= MODE_RST;
			mult_a_q       <= MULT_A_RST;
			incr_c_q       <= INCR_C_RST;
			quad_d_q       <= QUAD_D_RST;
			modulus_q      <= MODULUS_RST;
			cur_q          <= VALUE_BITS'(1);
			prev_q         <= VALUE_BITS'(1);
			for (int i = 0; i < NUM_BINS; i++)
				hist_q[i] <= '0;
		end else begin
			state_q <= state_d;

			if (fire)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;

			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:    mode_q    <= cfg_data[MODE_BITS-1:0];
					REG_MULT_A:  mult_a_q  <= cfg_data;
					REG_INCR_C:  incr_c_q  <= cfg_data;
					REG_QUAD_D:  quad_d_q  <= cfg_data;
					REG_MODULUS: modulus_q <= cfg_data;
					default: ;
				endcase
			end

			if (fire) begin
				if (kind_q == KIND_GEN) begin
					hist_q[gen_idx] <= cnt_inc;
					prev_q          <= cur_q;
					cur_q           <= VALUE_BITS'(r_q);
				end else if (kind_q == KIND_CLEAR) begin
					cur_q  <= VALUE_BITS'(1);
					prev_q <= VALUE_BITS'(1);
					for (int i = 0; i < NUM_BINS; i++)
						hist_q[i] <= '0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			sel_q  <= bin_select;
			flag_q <= 1'b0;
		end

		if (alu_done) begin
			unique case (state_q)
				ST_RED_X: x_q <= alu_res;
				ST_RED_C: t_q <= alu_res;
				ST_RED_A, ST_RED_P: p_q <= alu_res;
				default: r_q <= alu_res;
			endcase
			// bin search starts from NUM_BINS * next
			if (state_q == ST_ADD_C || state_q == ST_ADD_P) begin
				rem_q  <= RW'(NUM_BINS) * RW'(alu_res);
				dv_q   <= RW'(m_eff) << (QB - 1);
				bin_q  <= '0;
				bcnt_q <= '0;
			end
		end

		if (state_q == ST_INV_INIT) begin
			i_q    <= m_eff - CFG_BITS'(1);
			prod_q <= (x_q == '0) ? '0 : m_eff - x_q;
		end

		// walk i down from m-1 keeping prod = x*i mod m
		if (state_q == ST_INV) begin
			if (prod_q == CFG_BITS'(1)) begin
				p_q <= i_q;
			end else if (i_q == '0) begin
				p_q    <= '0;
				flag_q <= 1'b1;
			end else begin
				i_q    <= i_q - CFG_BITS'(1);
				prod_q <= prod_q - x_q + ((prod_q >= x_q) ? '0 : m_eff);
			end
		end

		if (state_q == ST_BIN) begin
			if (bin_ge)
				rem_q <= rem_q - dv_q;
			dv_q   <= dv_q >> 1;
			bin_q  <= QB'({bin_q, bin_ge});
			bcnt_q <= bcnt_q + BCW'(1);
		end

		if (fire) begin
			if (kind_q == KIND_GEN) begin
				value_q   <= VALUE_BITS'(r_q);
				bin_out_q <= SEL_BITS'(gen_idx);
				count_q   <= cnt_inc;
				no_inv_q  <= flag_q;
			end else if (kind_q == KIND_READ) begin
				value_q   <= '0;
				bin_out_q <= sel_q;
				count_q   <= sel_ok ? rd_cnt : '0;
				no_inv_q  <= 1'b0;
			end else begin
				value_q   <= '0;
				bin_out_q <= '0;
				count_q   <= '0;
				no_inv_q  <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign bin          = bin_out_q;
	assign bin_count    = count_q;
	assign no_inverse   = no_inv_q;

endmodule

// ===== rtl/cgh_checker.sv =====
// ----------------------------------------------------------------------------
// cgh_props
// Port-level properties of the congruential generator, bound to the top.
// ----------------------------------------------------------------------------
`include "congruential_generator_histogram_assert.svh"

module cgh_props #(
	parameter int VALUE_BITS = 16,
	parameter int COUNT_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input logic [VALUE_BITS-1:0] value,
	input logic [COUNT_BITS-1:0] bin_count
);

	// a stalled result stays offered, with value and bin_count unchanged
	`CGH_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid)
	`CGH_ASSERT_NXT(a_payload_hold, result_valid && !result_ready, $stable(value) && $stable(bin_count))

	// one item in flight: a transfer on the item side closes the input
	`CGH_ASSERT_NXT(a_single_item, item_valid && item_ready, !item_ready)

	// a finished item hands back to idle as its result appears
	`CGH_ASSERT_IMP(a_result_frees, $rose(result_valid), item_ready)

endmodule

bind congruential_generator_histogram cgh_props #(
	.VALUE_BITS(VALUE_BITS),
	.COUNT_BITS(COUNT_BITS)
) u_cgh_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.value       (value),
	.bin_count   (bin_count)
);

// ===== tb/cgh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgh_checker
// Watches the item, result and register channels of the congruential
// generator. Keeps its own copy of the registers, the two seed values and
// the histogram, predicts one outcome per item transfer and compares each
// result transfer, field by field, with the oldest outstanding outcome.
// ----------------------------------------------------------------------------
module cgh_checker import cgh_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  logic                    item_ready,
	input  logic [KIND_BITS-1:0]    kind,
	input  logic [SEL_BITS-1:0]     bin_select,
	input  logic                    result_valid,
	input  logic                    result_ready,
	input  logic [15:0]             value,
	input  logic [SEL_BITS-1:0]     bin,
	input  logic [15:0]             bin_count,
	input  logic                    no_inverse,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	output int                      errors,
	output int                      pending
);

	localparam int BINS = 10;

	typedef struct packed {
		logic [15:0]         value;
		logic [SEL_BITS-1:0] bin;
		logic [15:0]         count;
		logic                flag;
	} outcome_t;

	outcome_t outcomes[$];

	logic [MODE_BITS-1:0] cur_mode;
	logic [15:0]          cur_a, cur_c, cur_d, cur_m;
	logic [15:0]          seed_now, seed_prev;
	logic [15:0]          hist [BINS];
	int                   fails;

	always @(posedge clk or negedge arst_n) begin : track
		longint unsigned m, x, p, a, c, d, nxt, b, inv;
		longint r0, r1, t0, t1, q, tr, tt;
		outcome_t want, got;
		if (!arst_n) begin
			cur_mode  = MODE_RST;
			cur_a     = MULT_A_RST;
			cur_c     = INCR_C_RST;
			cur_d     = QUAD_D_RST;
			cur_m     = MODULUS_RST;
			seed_now  = 16'd1;
			seed_prev = 16'd1;
			for (int i = 0; i < BINS; i++)
				hist[i] = '0;
			outcomes.delete();
			fails = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:    cur_mode = cfg_data[MODE_BITS-1:0];
					REG_MULT_A:  cur_a = cfg_data;
					REG_INCR_C:  cur_c = cfg_data;
					REG_QUAD_D:  cur_d = cfg_data;
					REG_MODULUS: cur_m = cfg_data;
					default: ;
				endcase
			end

			if (item_valid && item_ready) begin
				want = '0;
				case (kind)
					KIND_GEN: begin
						m = (cur_m < MODULUS_MIN) ? MODULUS_MIN : cur_m;
						x = seed_now % m;
						p = seed_prev % m;
						a = cur_a % m;
						c = cur_c % m;
						d = cur_d % m;
						case (cur_mode)
							MODE_LIN:  nxt = (a * x + c) % m;
							MODE_QUAD: nxt = (((d * x) % m) * x + a * x + c) % m;
							MODE_FIB:  nxt = (x + p) % m;
							default: begin
								// extended Euclid; gcd other than 1 means no inverse
								r0 = longint'(m);
								r1 = longint'(x);
								t0 = 0;
								t1 = 1;
								while (r1 != 0) begin
									q  = r0 / r1;
									tr = r0 - q * r1;
									tt = t0 - q * t1;
									r0 = r1;
									r1 = tr;
									t0 = t1;
									t1 = tt;
								end
								if (r0 != 1) begin
									want.flag = 1'b1;
									inv = 0;
								end else begin
									if (t0 < 0)
										t0 = t0 + longint'(m);
									inv = longint'(t0) % m;
								end
								nxt = (a * inv + c) % m;
							end
						endcase
						seed_prev = seed_now;
						seed_now  = nxt[15:0];
						b = (BINS * nxt) / m;
						if (hist[b] != 16'hFFFF)
							hist[b] = hist[b] + 16'd1;
						want.value = nxt[15:0];
						want.bin   = b[SEL_BITS-1:0];
						want.count = hist[b];
					end
					KIND_READ: begin
						want.bin   = bin_select;
						want.count = (bin_select < BINS) ? hist[bin_select] : 16'd0;
					end
					KIND_CLEAR: begin
						for (int i = 0; i < BINS; i++)
							hist[i] = '0;
						seed_now  = 16'd1;
						seed_prev = 16'd1;
					end
					default: ;
				endcase
				outcomes.insert(outcomes.size(), want);
			end

			if (result_valid && result_ready) begin
				got = '{value: value, bin: bin, count: bin_count, flag: no_inverse};
				if (outcomes.size() == 0) begin
					$display("%0t: unexpected result: value %0d bin %0d count %0d flag %0b",
						$time, value, bin, bin_count, no_inverse);
					fails++;
				end else begin
					want = outcomes.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
						fails++;
					end
					if (got.bin !== want.bin) begin
						$display("%0t: bin expected %0d actual %0d", $time, want.bin, got.bin);
						fails++;
					end
					if (got.count !== want.count) begin
						$display("%0t: bin_count expected %0d actual %0d", $time,
							want.count, got.count);
						fails++;
					end
					if (got.flag !== want.flag) begin
						$display("%0t: no_inverse expected %0b actual %0b", $time,
							want.flag, got.flag);
						fails++;
					end
				end
			end

			errors  <= fails;
			pending <= outcomes.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the congruential generator with histogram: a directed pass
// over every mode, item kind and corner, then phases of random settings and
// random items with idle bursts on both sides. Checking is left to
// cgh_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import cgh_pkg::*;

	localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd3;
	localparam int BINS         = 10;
	localparam int RANDOM_ITEMS = 1300;
	localparam int CALM_ITEMS   = 150;

	logic                    clk;
	logic                    arst_n;
	logic                    item_valid;
	logic                    item_ready;
	logic [KIND_BITS-1:0]    kind;
	logic [SEL_BITS-1:0]     bin_select;
	logic                    result_valid;
	logic                    result_ready;
	logic [15:0]             value;
	logic [SEL_BITS-1:0]     bin;
	logic [15:0]             bin_count;
	logic                    no_inverse;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;
	int                      errors;
	int                      pending;
	bit                      calm;

	always #2 clk = ~clk;

	congruential_generator_histogram uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.bin_select   (bin_select),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.bin          (bin),
		.bin_count    (bin_count),
		.no_inverse   (no_inverse),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cgh_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.bin_select   (bin_select),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.bin          (bin),
		.bin_count    (bin_count),
		.no_inverse   (no_inverse),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	// receiver: bursts of ready, broken by stalls unless in the calm stretch
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic send_item(input logic [KIND_BITS-1:0] k, input logic [SEL_BITS-1:0] s);
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		bin_select <= s;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// every item answers once, so no outstanding result means the block is idle
	task automatic drain;
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] mode_word, input logic [15:0] a,
			input logic [15:0] c, input logic [15:0] d, input logic [15:0] m);
		write_reg(REG_MODE, mode_word);
		write_reg(REG_MULT_A, a);
		write_reg(REG_INCR_C, c);
		write_reg(REG_QUAD_D, d);
		write_reg(REG_MODULUS, m);
		// now and then a transfer to an unmapped index, which must change nothing
		if ($urandom_range(0, 7) == 0)
			write_reg(3'(REG_MODULUS + 1 + $urandom_range(0, 2)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_coeff();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		#20ms;
		$display("congruential_generator_histogram verification failed");
		$finish;
	end

	initial begin : stimulus
		int rnd;
		int burst;
		int roll;
		logic [MODE_BITS-1:0] md;
		logic [15:0] m;
		clk        = 1'b0;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		kind       = KIND_GEN;
		bin_select = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_MODE;
		cfg_data   = '0;
		calm       = 1'b0;
		rnd        = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: linear steps, reads in and out of range, odd kind, clear
		send_item(KIND_GEN, 4'd0);
		send_item(KIND_GEN, 4'hF);
		send_item(KIND_GEN, 4'd0);
		send_item(KIND_READ, 4'd0);
		send_item(KIND_READ, 4'(BINS - 1));
		send_item(KIND_READ, 4'hF);
		send_item(KIND_NONE, 4'hF);
		send_item(KIND_CLEAR, 4'd0);
		send_item(KIND_READ, 4'd0);

		drain;
		configure(16'(MODE_QUAD), MULT_A_RST, INCR_C_RST, QUAD_D_RST, MODULUS_RST);
		send_item(KIND_GEN, 4'd0);
		send_item(KIND_GEN, 4'd0);
		drain;
		configure(16'(MODE_FIB), MULT_A_RST, INCR_C_RST, QUAD_D_RST, MODULUS_RST);
		send_item(KIND_GEN, 4'd0);
		send_item(KIND_GEN, 4'd0);
		drain;
		configure(16'(MODE_INV), MULT_A_RST, INCR_C_RST, QUAD_D_RST, MODULUS_RST);
		send_item(KIND_GEN, 4'd0);
		send_item(KIND_GEN, 4'd0);

		// land on 4 mod 10, then ask for its inverse: there is none
		drain;
		configure(16'(MODE_LIN), 16'd0, 16'd4, QUAD_D_RST, 16'd10);
		send_item(KIND_GEN, 4'd0);
		drain;
		configure(16'(MODE_INV), 16'd0, 16'd4, QUAD_D_RST, 16'd10);
		send_item(KIND_GEN, 4'd0);

		// all coefficients and the modulus at full scale
		drain;
		configure(16'(MODE_QUAD), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(KIND_GEN, 4'd0);
		send_item(KIND_GEN, 4'd0);
		// modulus below 2 with a large value still held
		drain;
		configure(16'(MODE_QUAD), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		send_item(KIND_GEN, 4'd0);
		drain;
		configure(16'(MODE_FIB), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
		send_item(KIND_GEN, 4'd0);
		// longest inverse searches
		drain;
		configure(16'(MODE_INV), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(KIND_GEN, 4'd0);
		send_item(KIND_GEN, 4'd0);
		send_item(KIND_READ, 4'(BINS - 1));

		while (rnd < RANDOM_ITEMS) begin
			drain;
			if (rnd >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			md   = MODE_BITS'($urandom_range(0, 3));
			roll = $urandom_range(0, 9);
			// the inverse search walks every candidate below m, so keep its modulus small
			if (roll == 0)
				m = 16'($urandom_range(0, 1));
			else if (roll == 1 && md != MODE_INV)
				m = 16'hFFFF;
			else if (roll == 2 && md != MODE_INV)
				m = 16'($urandom);
			else if (roll < 5)
				m = 16'($urandom_range(2, 16));
			else
				m = 16'($urandom_range(2, 400));
			configure(($urandom_range(0, 1) ? (16'($urandom) & 16'hFFFC) : 16'h0000) | 16'(md),
				pick_coeff(), pick_coeff(), pick_coeff(), m);
			burst = $urandom_range(30, 80);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					send_item(KIND_GEN, 4'($urandom));
				else if (roll < 88)
					send_item(KIND_READ, ($urandom_range(0, 3) == 0) ? 4'($urandom) :
						4'($urandom_range(0, BINS - 1)));
				else if (roll < 94)
					send_item(KIND_CLEAR, 4'($urandom));
				else
					send_item(KIND_NONE, 4'($urandom));
				rnd++;
			end
		end

		drain;
		repeat (80) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("congruential_generator_histogram verification clean");
		else
			$display("congruential_generator_histogram verification failed");
		$finish;
	end

endmodule
